/* hdl/stnl_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted time table lookup package
// Shared constants, payload types, command codes and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package stnl_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int FRACTION_BITS = 8;

  localparam int IDX_W   = 10;
  localparam int CFG_W   = 11;
  localparam int TIME_W  = 32;
  localparam int QUERY_W = 40;

  localparam int ADDR_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int SCALED_W = TIME_W + FRACTION_BITS;
  localparam int CMP_W    = ((SCALED_W > QUERY_W) ? SCALED_W : QUERY_W) + 1;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_NEAREST = 2'd1,
    CMD_READ    = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [IDX_W-1:0]          entry_index;
    logic signed [TIME_W-1:0]  entry_time;
    logic signed [QUERY_W-1:0] query_time;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]         result_index;
    logic signed [TIME_W-1:0] result_time;
    logic                     out_of_range;
  } res_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] cnt);
    if (32'(cnt) > 32'(TABLE_DEPTH)) begin
      return CNT_W'(TABLE_DEPTH);
    end
    return CNT_W'(cnt);
  endfunction

  function automatic logic signed [CMP_W-1:0] scale_time(
    input logic signed [TIME_W-1:0] t
  );
    logic signed [CMP_W-1:0] wide;
    wide = CMP_W'(t);
    return wide <<< FRACTION_BITS;
  endfunction

endpackage

`default_nettype wire

/* hdl/sorted_time_table_nearest_lookup_unit.sv */
// ----------------------------------------------------------------------------
// Sorted time table nearest lookup unit
// Holds ascending timestamps in a RAM and serves writes, indexed reads and
// nearest-index queries on a fixed-point time.
//
// An item is transferred when start_i is high and busy is low. A write
// gives no result; busy stays low. A read raises busy for one cycle and
// its result appears in the cycle after that. A nearest query on an empty
// table gives its result in the next cycle; otherwise it runs a binary
// search with one RAM probe per cycle, since the RAM has a single read
// port with registered read data, then up to two further probes for the
// neighbours, and the result follows in the next cycle. Each result is
// shown on result_o for exactly one cycle with done_o high; the receiver
// cannot stall it, and the next item may be transferred in that same
// cycle. The entry count is written through cfg_we_i and cfg_wdata_i; the
// user must write it only while the unit is idle, as the unit itself does
// not enforce this. Reset clears the count and the control state; the
// table contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_time_table_nearest_lookup_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  stnl_pkg::req_t             req_i,
  output logic                       busy,
  output logic                       done_o,
  output stnl_pkg::res_t             result_o,
  input  logic                       cfg_we_i,
  input  logic [stnl_pkg::CFG_W-1:0] cfg_wdata_i
);

  import stnl_pkg::*;

  logic [CFG_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_eff;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [TIME_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [TIME_W-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign count_eff = eff_count(count_q);

  stnl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .count_i     (count_eff),
    .busy_o      (busy),
    .done_o      (done_o),
    .res_o       (result_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  stnl_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (TIME_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

/* hdl/stnl_ram.sv */
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stnl_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/stnl_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted time table lookup controller
// Sequences table writes, indexed reads and the binary search with its
// final neighbour comparison, one memory probe per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stnl_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  stnl_pkg::req_t              req_i,
  input  logic [stnl_pkg::CNT_W-1:0]  count_i,
  output logic                        busy_o,
  output logic                        done_o,
  output stnl_pkg::res_t              res_o,
  output logic                        mem_we_o,
  output logic [stnl_pkg::ADDR_W-1:0] mem_waddr_o,
  output logic [stnl_pkg::TIME_W-1:0] mem_wdata_o,
  output logic [stnl_pkg::ADDR_W-1:0] mem_raddr_o,
  input  logic [stnl_pkg::TIME_W-1:0] mem_rdata_i
);

  import stnl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_LO   = 3'd3;
  localparam logic [2:0] S_PREV = 3'd4;

  logic [2:0]                state_q, state_d;
  logic [CNT_W-1:0]          lo_q, lo_d;
  logic [CNT_W-1:0]          hi_q, hi_d;
  logic [CNT_W-1:0]          mid_q, mid_d;
  logic signed [QUERY_W-1:0] q_q, q_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic signed [CMP_W-1:0]   dnext_q, dnext_d;
  logic                      done_q, done_d;
  res_t                      res_q, res_d;

  logic signed [CMP_W-1:0] s_rd;
  logic signed [CMP_W-1:0] qx;
  logic signed [CMP_W-1:0] dprev;
  logic                    lt;
  logic [CNT_W-1:0]        lo_n;
  logic [CNT_W-1:0]        hi_n;
  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        lo_m1;

  assign s_rd    = scale_time(mem_rdata_i);
  assign qx      = CMP_W'(q_q);
  assign dprev   = qx - s_rd;
  assign lt      = s_rd < qx;
  assign lo_n    = lt ? (mid_q + CNT_W'(1)) : lo_q;
  assign hi_n    = lt ? hi_q : mid_q;
  assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
  assign lo_m1   = lo_q - CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    q_d         = q_q;
    idx_d       = idx_q;
    dnext_d     = dnext_q;
    done_d      = 1'b0;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ADDR_W'(req_i.entry_index);
    mem_wdata_o = req_i.entry_time;
    mem_raddr_o = ADDR_W'(mid_q);

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (req_i.cmd)
            CMD_WRITE: begin
              mem_we_o = 32'(req_i.entry_index) < 32'(TABLE_DEPTH);
            end
            CMD_READ: begin
              idx_d       = req_i.entry_index;
              mem_raddr_o = ADDR_W'(req_i.entry_index);
              state_d     = S_READ;
            end
            CMD_NEAREST: begin
              q_d = req_i.query_time;
              if (count_i == '0) begin
                done_d             = 1'b1;
                res_d.result_index = '0;
                res_d.result_time  = '0;
                res_d.out_of_range = 1'b1;
              end else begin
                lo_d        = '0;
                hi_d        = count_i;
                mid_d       = count_i >> 1;
                mem_raddr_o = ADDR_W'(count_i >> 1);
                state_d     = S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        done_d             = 1'b1;
        state_d            = S_IDLE;
        res_d.result_index = '0;
        if (32'(idx_q) < 32'(count_i)) begin
          res_d.result_time  = mem_rdata_i;
          res_d.out_of_range = 1'b0;
        end else begin
          res_d.result_time  = '0;
          res_d.out_of_range = 1'b1;
        end
      end
      S_SRCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        res_d.result_time  = '0;
        res_d.out_of_range = 1'b0;
        if (lo_n < hi_n) begin
          mid_d       = mid_sum[CNT_W:1];
          mem_raddr_o = ADDR_W'(mid_sum[CNT_W:1]);
        end else if (lo_n == count_i) begin
          done_d             = 1'b1;
          state_d            = S_IDLE;
          res_d.result_index = IDX_W'(count_i - CNT_W'(1));
        end else if (lo_n == '0) begin
          done_d             = 1'b1;
          state_d            = S_IDLE;
          res_d.result_index = '0;
        end else begin
          mem_raddr_o = ADDR_W'(lo_n);
          state_d     = S_LO;
        end
      end
      S_LO: begin
        if (s_rd == qx) begin
          done_d             = 1'b1;
          state_d            = S_IDLE;
          res_d.result_index = IDX_W'(lo_q);
        end else begin
          dnext_d     = s_rd - qx;
          mem_raddr_o = ADDR_W'(lo_m1);
          state_d     = S_PREV;
        end
      end
      S_PREV: begin
        done_d             = 1'b1;
        state_d            = S_IDLE;
        res_d.result_index = (dprev <= dnext_q) ? IDX_W'(lo_m1) : IDX_W'(lo_q);
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    q_q     <= q_d;
    idx_q   <= idx_d;
    dnext_q <= dnext_d;
    res_q   <= res_d;
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire
